// ===== rtl/i64div_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64div_pkg
// Shared constants and types of the integer divider: selector codes,
// stream widths and the control word that rides with each request.
// ----------------------------------------------------------------------------
package i64div_pkg;

   // Width of the dividend, divisor and quotient fields on the ports.
   localparam int FIELD_WIDTH     = 64;
   localparam int REQ_TDATA_WIDTH = 2 * FIELD_WIDTH;
   localparam int RSP_TDATA_WIDTH = FIELD_WIDTH;

   // Division kind carried in req_tuser.
   localparam logic ACTION_UNSIGNED = 1'b0;
   localparam logic ACTION_SIGNED   = 1'b1;

   // Control that travels alongside the operands through the cell row.
   typedef struct packed {
      logic valid;     // A request occupies this stage.
      logic negate;    // Operand signs differ in signed mode.
      logic zero_div;  // Divisor is zero; the quotient is forced to zero.
   } step_ctrl_type;

endpackage

// ===== rtl/i64div_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64div_prep
// Operand conditioning: takes magnitudes in signed mode, notes the sign of
// the result and a zero divisor, and registers the head of the cell row.
// ----------------------------------------------------------------------------
module i64div_prep
   import i64div_pkg::*;
#(
   parameter int DATA_WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   action,
   input  logic [FIELD_WIDTH-1:0] dividend,
   input  logic [FIELD_WIDTH-1:0] divisor,
   output step_ctrl_type          ctrl,
   output logic [DATA_WIDTH-1:0]  num,
   output logic [DATA_WIDTH-1:0]  den
);

   logic [DATA_WIDTH-1:0] a;
   logic [DATA_WIDTH-1:0] b;
   logic                  a_neg;
   logic                  b_neg;
   step_ctrl_type         ctrl_ff;
   step_ctrl_type         ctrl_in;
   logic [DATA_WIDTH-1:0] num_ff;
   logic [DATA_WIDTH-1:0] num_in;
   logic [DATA_WIDTH-1:0] den_ff;
   logic [DATA_WIDTH-1:0] den_in;

   assign a     = dividend[DATA_WIDTH-1:0];
   assign b     = divisor[DATA_WIDTH-1:0];
   assign a_neg = (action == ACTION_SIGNED) && a[DATA_WIDTH-1];
   assign b_neg = (action == ACTION_SIGNED) && b[DATA_WIDTH-1];

   always_comb begin
      ctrl_in.valid    = accept;
      ctrl_in.negate   = a_neg ^ b_neg;
      ctrl_in.zero_div = (b == '0);
      num_in           = a_neg ? (DATA_WIDTH'(0) - a) : a;
      den_in           = b_neg ? (DATA_WIDTH'(0) - b) : b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign ctrl = ctrl_ff;
   assign num  = num_ff;
   assign den  = den_ff;

endmodule

// ===== rtl/i64div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64div_cell
// One restoring division step: shifts the next dividend bit into the partial
// remainder, subtracts the divisor when it fits and shifts out a quotient bit.
// ----------------------------------------------------------------------------
module i64div_cell
   import i64div_pkg::*;
#(
   parameter int DATA_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  step_ctrl_type         ctrl_i,
   input  logic [DATA_WIDTH-1:0] rem_i,
   input  logic [DATA_WIDTH-1:0] quot_i,
   input  logic [DATA_WIDTH-1:0] num_i,
   input  logic [DATA_WIDTH-1:0] den_i,
   output step_ctrl_type         ctrl_o,
   output logic [DATA_WIDTH-1:0] rem_o,
   output logic [DATA_WIDTH-1:0] quot_o,
   output logic [DATA_WIDTH-1:0] num_o,
   output logic [DATA_WIDTH-1:0] den_o
);

   logic [DATA_WIDTH:0]   rem_ext;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;
   step_ctrl_type         ctrl_ff;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] rem_in;
   logic [DATA_WIDTH-1:0] quot_ff;
   logic [DATA_WIDTH-1:0] quot_in;
   logic [DATA_WIDTH-1:0] num_ff;
   logic [DATA_WIDTH-1:0] num_in;
   logic [DATA_WIDTH-1:0] den_ff;

   // The remainder stays below the divisor, so after the shift it fits in
   // one extra bit and the difference lies from minus the divisor up to just
   // below the divisor. The top bit of the difference is then its sign, and a
   // difference that is taken fits back in DATA_WIDTH.
   always_comb begin
      rem_ext = {rem_i, num_i[DATA_WIDTH-1]};
      diff    = rem_ext - {1'b0, den_i};
      fits    = ~diff[DATA_WIDTH];
      rem_in  = fits ? diff[DATA_WIDTH-1:0] : rem_ext[DATA_WIDTH-1:0];
      quot_in = {quot_i[DATA_WIDTH-2:0], fits};
      num_in  = {num_i[DATA_WIDTH-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_i;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      num_ff  <= num_in;
      den_ff  <= den_i;
   end

   assign ctrl_o = ctrl_ff;
   assign rem_o  = rem_ff;
   assign quot_o = quot_ff;
   assign num_o  = num_ff;
   assign den_o  = den_ff;

endmodule

// ===== rtl/i64div_post.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64div_post
// Result stage: applies the sign and the zero-divisor rule to the quotient
// from the last cell and holds it on the response channel until taken.
// ----------------------------------------------------------------------------
module i64div_post
   import i64div_pkg::*;
#(
   parameter int DATA_WIDTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  step_ctrl_type              ctrl,
   input  logic [DATA_WIDTH-1:0]      quot,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   logic                       valid_ff;
   logic                       valid_in;
   logic [RSP_TDATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0]      signed_q;

   always_comb begin
      if (ctrl.zero_div) begin
         signed_q = '0;
      end else if (ctrl.negate) begin
         signed_q = DATA_WIDTH'(0) - quot;
      end else begin
         signed_q = quot;
      end
      if (ctrl.valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.valid) begin
         data_ff <= RSP_TDATA_WIDTH'(signed_q);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ===== rtl/int64_signed_unsigned_divider_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int64_signed_unsigned_divider_core
// Signed or unsigned integer divider returning the quotient, built as a row
// of restoring-division cells, one quotient bit per cell.
// ----------------------------------------------------------------------------
// Pipeline: the operand stage loads at the accepting edge, then one cell per
// quotient bit and one result stage register the request in that order.
// A single request is in the cell row at a time, and the next is taken as
// the response is taken.
// Reset clears the stage valid bits, the busy flag and the response valid.
module int64_signed_unsigned_divider_core
   import i64div_pkg::*;
#(
   parameter int DATA_WIDTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,  // [63:0] dividend, [127:64] divisor
   input  logic                       req_tuser,  // [0] action
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata   // [63:0] quotient
);

   logic                  busy_ff;
   logic                  busy_in;
   logic                  req_fire;
   logic                  rsp_fire;
   step_ctrl_type         ctrl_s [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] rem_s  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] quot_s [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] num_s  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] den_s  [0:DATA_WIDTH];

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = !busy_ff || rsp_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (req_fire) begin
         busy_in = 1'b1;
      end else if (rsp_fire) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   i64div_prep #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_fire),
      .action   (req_tuser),
      .dividend (req_tdata[FIELD_WIDTH-1:0]),
      .divisor  (req_tdata[REQ_TDATA_WIDTH-1:FIELD_WIDTH]),
      .ctrl     (ctrl_s[0]),
      .num      (num_s[0]),
      .den      (den_s[0])
   );

   assign rem_s[0]  = '0;
   assign quot_s[0] = '0;

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      i64div_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctrl_i (ctrl_s[i]),
         .rem_i  (rem_s[i]),
         .quot_i (quot_s[i]),
         .num_i  (num_s[i]),
         .den_i  (den_s[i]),
         .ctrl_o (ctrl_s[i+1]),
         .rem_o  (rem_s[i+1]),
         .quot_o (quot_s[i+1]),
         .num_o  (num_s[i+1]),
         .den_o  (den_s[i+1])
      );
   end

   i64div_post #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_post (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl_s[DATA_WIDTH]),
      .quot       (quot_s[DATA_WIDTH]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/i64div_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64div_checker
// Port-level checks of the divider: response hold rules and the one-request-
// in-flight behavior seen on the request side.
// ----------------------------------------------------------------------------
module i64div_checker
   import i64div_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response data changed while stalled");

   // A request just taken occupies the cell row, so no second one follows.
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in flight");

   // A waiting response means the divider is still occupied.
   a_busy_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while a response is pending");

endmodule

bind int64_signed_unsigned_divider_core i64div_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/int64_signed_unsigned_divider_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int64_signed_unsigned_divider_core_test
// Self-checking bench for the 64-bit signed/unsigned divider. A queue of
// requests, directed corner cases first and then random operands of every
// bit length, feeds a clocked stream driver. A clocked monitor compares each
// quotient with a restoring long-division predictor. Both stream sides idle
// at random, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module int64_signed_unsigned_divider_core_test;
   import i64div_pkg::*;

   localparam int          LATENCY        = FIELD_WIDTH + 2;
   localparam int          DRAIN_CYCLES   = LATENCY + 16;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          RANDOM_COUNT   = 1425;
   localparam int unsigned LONG_HOLD      = 600;
   localparam int unsigned HOLD_AT_COUNT  = 40;

   typedef logic [FIELD_WIDTH-1:0] word_type;

   localparam word_type MOST_NEG = {1'b1, {(FIELD_WIDTH - 1){1'b0}}};
   localparam word_type MOST_POS = {1'b0, {(FIELD_WIDTH - 1){1'b1}}};
   localparam word_type ALL_ONES = '1;

   typedef struct {
      logic     action;
      word_type dividend;
      word_type divisor;
      bit       wait_idle;  // Hold this request back until all quotients are in.
   } div_request_type;

   typedef struct {
      logic     action;
      word_type dividend;
      word_type divisor;
      word_type quotient;
   } quotient_entry_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;  // [63:0] dividend, [127:64] divisor
   logic                       req_tuser  = ACTION_UNSIGNED;  // [0] action
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;  // [63:0] quotient

   div_request_type    pending_q[$];
   quotient_entry_type quotient_q[$];

   int unsigned error_count  = 0;
   int unsigned accept_count = 0;
   int unsigned rsp_count    = 0;
   int unsigned n_signed     = 0;
   int unsigned n_zero_div   = 0;

   int64_signed_unsigned_divider_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Restoring long division, one quotient bit per step from the top down.
   function automatic word_type udiv_restoring(word_type n, word_type d);
      logic [FIELD_WIDTH:0] rem;
      word_type             q;
      rem = '0;
      q   = '0;
      if (d == '0 || n == '0) return '0;
      for (int i = FIELD_WIDTH - 1; i >= 0; i--) begin
         rem = {rem[FIELD_WIDTH-1:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic word_type predict_quotient(logic act, word_type a, word_type b);
      logic     neg_a, neg_b;
      word_type mag_a, mag_b, q;
      if (act == ACTION_SIGNED) begin
         neg_a = a[FIELD_WIDTH-1];
         neg_b = b[FIELD_WIDTH-1];
         mag_a = neg_a ? word_type'(-a) : a;
         mag_b = neg_b ? word_type'(-b) : b;
         q     = udiv_restoring(mag_a, mag_b);
         // Negating the most negative magnitude wraps back onto itself.
         if (neg_a != neg_b) q = word_type'(-q);
      end else begin
         q = udiv_restoring(a, b);
      end
      return q;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(24, 4);
      return $urandom_range(160, 40);
   endfunction

   function automatic word_type rand_operand();
      word_type    v;
      int unsigned kind;
      v    = {$urandom, $urandom};
      kind = $urandom_range(9);
      case (kind)
         0, 1, 2: ;
         3, 4, 5: v = v >> $urandom_range(FIELD_WIDTH - 1);
         6: v = word_type'(-(v >> $urandom_range(FIELD_WIDTH - 1, FIELD_WIDTH / 2)));
         7: begin
            case ($urandom_range(9))
               0: v = '0;
               1: v = word_type'(1);
               2: v = ALL_ONES;
               3: v = MOST_NEG;
               4: v = MOST_POS;
               5: v = word_type'(1) << $urandom_range(FIELD_WIDTH - 1);
               6: v = (word_type'(1) << $urandom_range(FIELD_WIDTH - 1)) - 1'b1;
               7: v = 64'hFF00_0000_0000_0000;
               8: v = 64'hFFFF_0000_0000_0000;
               default: v = 64'hFFFF_FFFF_0000_0000;
            endcase
         end
         default: v = v >> $urandom_range(FIELD_WIDTH - 1, FIELD_WIDTH - 12);
      endcase
      return v;
   endfunction

   task automatic add_request(logic act, word_type a, word_type b, bit wait_idle = 1'b0);
      div_request_type item;
      item.action    = act;
      item.dividend  = a;
      item.divisor   = b;
      item.wait_idle = wait_idle;
      pending_q.push_back(item);
      if (act == ACTION_SIGNED) n_signed++;
      if (b == '0) n_zero_div++;
   endtask

   // Request driver: presents the next pending request once the bus is free.
   always @(posedge clock) begin : drive_proc
      div_request_type item;
      int unsigned     gap_left;
      int unsigned     sent;
      int unsigned     done_seen;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= ACTION_UNSIGNED;
         gap_left   = 0;
         sent       = 0;
         done_seen  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) done_seen++;
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0 &&
                         !(pending_q[0].wait_idle && done_seen != sent)) begin
               item = pending_q.pop_front();
               req_tdata  <= {item.divisor, item.dividend};
               req_tuser  <= item.action;
               req_tvalid <= 1'b1;
               quotient_q.push_back('{item.action, item.dividend, item.divisor,
                  predict_quotient(item.action, item.dividend, item.divisor)});
               sent++;
               gap_left = (((sent / 100) % 5) == 2) ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side: random stalls, stall-free windows and one long hold.
   always @(posedge clock) begin : sink_proc
      int unsigned stall_left;
      int unsigned taken;
      bit          hold_done;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         taken      = 0;
         hold_done  = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) taken++;
         if (!hold_done && taken == HOLD_AT_COUNT) begin
            hold_done  = 1'b1;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && ((taken / 50) % 4) != 1 &&
                      $urandom_range(99) < 6) begin
            stall_left = pick_gap() + 1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Quotient checker. It counts accepted requests itself, so that a response
   // with no accepted request behind it is caught.
   always @(posedge clock) begin : check_proc
      quotient_entry_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_count >= accept_count || quotient_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, no request outstanding: expected none, got %h",
                        $time, rsp_tdata);
            end else begin
               want = quotient_q.pop_front();
               if (rsp_tdata !== want.quotient) begin
                  error_count++;
                  $display("%0t: quotient mismatch, %s %h / %h: expected %h, got %h",
                           $time, (want.action == ACTION_SIGNED) ? "signed" : "unsigned",
                           want.dividend, want.divisor, want.quotient, rsp_tdata);
               end
            end
            rsp_count++;
         end
         if (req_tvalid && req_tready) accept_count++;
      end
   end

   always @(posedge clock) begin : watchdog_proc
      int unsigned quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or response accepted for %0d cycles", $time, quiet);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus_proc
      word_type a, b;
      logic     act;
      // Unsigned corner cases.
      add_request(ACTION_UNSIGNED, '0, '0);
      add_request(ACTION_UNSIGNED, word_type'(5), '0);
      add_request(ACTION_UNSIGNED, '0, word_type'(7));
      add_request(ACTION_UNSIGNED, word_type'(3), word_type'(10));
      add_request(ACTION_UNSIGNED, ALL_ONES, word_type'(1));
      add_request(ACTION_UNSIGNED, MOST_NEG, word_type'(1));
      add_request(ACTION_UNSIGNED, ALL_ONES, ALL_ONES);
      add_request(ACTION_UNSIGNED, ALL_ONES - 1'b1, ALL_ONES);
      add_request(ACTION_UNSIGNED, ALL_ONES, word_type'(2));
      add_request(ACTION_UNSIGNED, word_type'(100), word_type'(7));
      add_request(ACTION_UNSIGNED, ALL_ONES, 64'hFF00_0000_0000_0000);
      add_request(ACTION_UNSIGNED, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_0001_0000);
      add_request(ACTION_UNSIGNED, 64'hFFFF_0000_0000_0000, MOST_NEG);
      // Signed corner cases, the wrapping most negative by minus one first.
      add_request(ACTION_SIGNED, MOST_NEG, ALL_ONES);
      add_request(ACTION_SIGNED, MOST_NEG, word_type'(1));
      add_request(ACTION_SIGNED, word_type'(-7), word_type'(2));
      add_request(ACTION_SIGNED, word_type'(7), word_type'(-2));
      add_request(ACTION_SIGNED, word_type'(-7), word_type'(-2));
      add_request(ACTION_SIGNED, '0, ALL_ONES);
      add_request(ACTION_SIGNED, word_type'(-5), '0);
      add_request(ACTION_SIGNED, word_type'(5), word_type'(-10));
      add_request(ACTION_SIGNED, MOST_POS, MOST_NEG);
      add_request(ACTION_SIGNED, MOST_NEG, MOST_NEG);
      add_request(ACTION_SIGNED, MOST_NEG, word_type'(2));

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         act = 1'($urandom_range(1));
         a   = rand_operand();
         case ($urandom_range(19))
            0, 1, 2: b = a >> $urandom_range(FIELD_WIDTH - 1, 1);
            3:       b = a;
            4:       b = a + 1'b1;
            5:       b = a - 1'b1;
            default: b = rand_operand();
         endcase
         add_request(act, a, b, (i == 0) || (i == 700));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_q.size() > 0 || req_tvalid || rsp_count != accept_count ||
             quotient_q.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (quotient_q.size() > 0) begin
         error_count++;
         $display("%0t: %0d quotients never arrived: expected %0d, got 0",
                  $time, quotient_q.size(), quotient_q.size());
      end

      $display("Checked %0d quotients: %0d signed, %0d unsigned, %0d with a zero divisor,",
               rsp_count, n_signed, accept_count - n_signed, n_zero_div);
      $display("under random stalls on both sides and one long response hold; %0d errors.",
               error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/i64div_pkg.sv
rtl/i64div_prep.sv
rtl/i64div_cell.sv
rtl/i64div_post.sv
rtl/int64_signed_unsigned_divider_core.sv
rtl/i64div_checker.sv
tb/int64_signed_unsigned_divider_core_test.sv
